FILE: hdl/lgge_pkg.sv
package lgge_pkg;

    localparam int CFG_DATA_W = 7;
    localparam int CFG_INDEX_W = 2;
    localparam int GEN_COUNT_W = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_WIDTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_GRID_HEIGHT = 2'd1;

    localparam logic [CFG_DATA_W-1:0] DIM_MIN = 7'd2;
    localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd64;

    localparam logic [1:0] FUNC_WRITE = 2'd0;
    localparam logic [1:0] FUNC_READ = 2'd1;
    localparam logic [1:0] FUNC_RUN = 2'd2;

    localparam logic [3:0] SURVIVE_LOW = 4'd2;
    localparam logic [3:0] SURVIVE_HIGH = 4'd3;
    localparam logic [3:0] BIRTH_COUNT = 4'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CELL_RD,
        ST_CELL_WR,
        ST_GEN_START,
        ST_GEN_PRIME,
        ST_GEN_ROW,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic latch_in;
        logic cell_capture;
        logic cell_write;
        logic gen_start;
        logic gen_prime;
        logic gen_row;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic count_zero;
        logic last_row;
        logic gens_one;
        logic changed;
        logic out_free;
    } sts_t;

endpackage

FILE: hdl/lgge_ctrl.sv
module lgge_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_stall,
    input  logic [1:0]     func,
    input  lgge_pkg::sts_t sts,
    output lgge_pkg::cmd_t cmd
);
    import lgge_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    case (func)
                        FUNC_WRITE: state_next = ST_CELL_WR;
                        FUNC_READ:  state_next = ST_CELL_RD;
                        FUNC_RUN:   state_next = sts.count_zero ? ST_FINISH : ST_GEN_START;
                        default:    state_next = ST_FINISH;
                    endcase
                end
            end
            ST_CELL_RD:
            begin
                cmd.cell_capture = 1'b1;
                state_next = ST_FINISH;
            end
            ST_CELL_WR:
            begin
                cmd.cell_write = 1'b1;
                state_next = ST_FINISH;
            end
            ST_GEN_START:
            begin
                cmd.gen_start = 1'b1;
                state_next = ST_GEN_PRIME;
            end
            ST_GEN_PRIME:
            begin
                cmd.gen_prime = 1'b1;
                state_next = ST_GEN_ROW;
            end
            ST_GEN_ROW:
            begin
                cmd.gen_row = 1'b1;
                if (sts.last_row)
                begin
                    // a generation with no change is a still life: nothing more to do
                    if (sts.gens_one || !sts.changed)
                    begin
                        state_next = ST_FINISH;
                    end
                    else
                    begin
                        state_next = ST_GEN_START;
                    end
                end
            end
            ST_FINISH:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/lgge_datapath.sv
module lgge_datapath #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  lgge_pkg::cmd_t                        cmd,
    output lgge_pkg::sts_t                        sts,
    input  logic                                  cfg_valid,
    input  logic [lgge_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [lgge_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [5:0]                            row_index,
    input  logic [5:0]                            col_index,
    input  logic                                  alive_in,
    input  logic [lgge_pkg::GEN_COUNT_W-1:0]      generation_count,
    input  logic                                  out_stall,
    output logic                                  out_valid,
    output logic                                  alive_out
);
    import lgge_pkg::*;

    localparam int RW = $clog2(MAX_HEIGHT);
    localparam int CLW = $clog2(MAX_WIDTH);
    localparam int WCW = $clog2(MAX_WIDTH + 1);
    localparam int HCW = $clog2(MAX_HEIGHT + 1);

    logic [MAX_WIDTH-1:0] grid_mem [MAX_HEIGHT];
    logic [MAX_HEIGHT-1:0] row_vld_reg;

    logic [CFG_DATA_W-1:0] width_reg;
    logic [CFG_DATA_W-1:0] height_reg;
    logic [WCW-1:0] w_clamp;
    logic [HCW-1:0] h_clamp;

    logic [MAX_WIDTH-1:0] rd_data_reg;
    logic rd_vld_reg;
    logic [MAX_WIDTH-1:0] rd_row;

    logic [MAX_WIDTH-1:0] above_reg;
    logic [MAX_WIDTH-1:0] mid_reg;
    logic [MAX_WIDTH-1:0] below;
    logic [RW-1:0] row_cnt_reg;
    logic [GEN_COUNT_W-1:0] gen_cnt_reg;
    logic changed_reg;

    logic [5:0] row_reg;
    logic [5:0] col_reg;
    logic alive_reg;
    logic result_reg;
    logic out_valid_reg;
    logic alive_out_reg;

    logic in_range;
    logic [CLW-1:0] col_sel;
    logic [MAX_WIDTH-1:0] col_mask;
    logic [MAX_WIDTH-1:0] next_row;
    logic [MAX_WIDTH-1:0] mod_row;
    logic changed_now;
    logic last_row;

    logic rd_en;
    logic [RW-1:0] rd_addr;
    logic [RW-1:0] rd_addr_ahead;
    logic wr_en;
    logic [RW-1:0] wr_addr;
    logic [MAX_WIDTH-1:0] wr_data;

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg <= DIM_RESET;
            height_reg <= DIM_RESET;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_GRID_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == CFG_GRID_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    always_comb
    begin
        if (width_reg < DIM_MIN)
        begin
            w_clamp = WCW'(DIM_MIN);
        end
        else if (32'(width_reg) > MAX_WIDTH)
        begin
            w_clamp = WCW'(MAX_WIDTH);
        end
        else
        begin
            w_clamp = WCW'(width_reg);
        end

        if (height_reg < DIM_MIN)
        begin
            h_clamp = HCW'(DIM_MIN);
        end
        else if (32'(height_reg) > MAX_HEIGHT)
        begin
            h_clamp = HCW'(MAX_HEIGHT);
        end
        else
        begin
            h_clamp = HCW'(height_reg);
        end
    end

    assign rd_row = rd_vld_reg ? rd_data_reg : '0;
    assign last_row = (row_cnt_reg == RW'(h_clamp - HCW'(1)));
    assign below = last_row ? '0 : rd_row;
    assign in_range = (32'(row_reg) < 32'(h_clamp)) && (32'(col_reg) < 32'(w_clamp));
    assign col_sel = CLW'(col_reg);

    // neighbour count and b3/s23 rule across the row
    always_comb
    begin
        logic [MAX_WIDTH+1:0] a_pad;
        logic [MAX_WIDTH+1:0] m_pad;
        logic [MAX_WIDTH+1:0] b_pad;
        logic [3:0] nbr;
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            col_mask[x] = (x < int'(w_clamp));
        end
        a_pad = {1'b0, above_reg & col_mask, 1'b0};
        m_pad = {1'b0, mid_reg & col_mask, 1'b0};
        b_pad = {1'b0, below & col_mask, 1'b0};
        for (int x = 0; x < MAX_WIDTH; x++)
        begin
            nbr = 4'(a_pad[x]) + 4'(a_pad[x+1]) + 4'(a_pad[x+2])
                + 4'(m_pad[x]) + 4'(m_pad[x+2])
                + 4'(b_pad[x]) + 4'(b_pad[x+1]) + 4'(b_pad[x+2]);
            if (!col_mask[x])
            begin
                next_row[x] = mid_reg[x];
            end
            else if (mid_reg[x])
            begin
                next_row[x] = (nbr >= SURVIVE_LOW) && (nbr <= SURVIVE_HIGH);
            end
            else
            begin
                next_row[x] = (nbr == BIRTH_COUNT);
            end
        end
    end

    assign changed_now = |(next_row ^ mid_reg);

    always_comb
    begin
        mod_row = rd_row;
        mod_row[col_sel] = alive_reg;
    end

    // memory port control
    assign rd_addr_ahead = row_cnt_reg + RW'(2);
    assign rd_en = cmd.latch_in | cmd.gen_start | cmd.gen_prime | cmd.gen_row;

    always_comb
    begin
        if (cmd.latch_in)
        begin
            rd_addr = RW'(row_index);
        end
        else if (cmd.gen_start)
        begin
            rd_addr = '0;
        end
        else if (cmd.gen_prime)
        begin
            rd_addr = RW'(1);
        end
        else
        begin
            rd_addr = rd_addr_ahead;
        end
    end

    assign wr_en = (cmd.cell_write & in_range) | cmd.gen_row;
    assign wr_addr = cmd.gen_row ? row_cnt_reg : RW'(row_reg);
    assign wr_data = cmd.gen_row ? next_row : mod_row;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            grid_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= grid_mem[rd_addr];
            rd_vld_reg <= row_vld_reg[rd_addr];
        end
    end

    // rows never written read as dead
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_vld_reg <= '0;
        end
        else if (wr_en)
        begin
            row_vld_reg[wr_addr] <= 1'b1;
        end
    end

    // sweep and operand registers
    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            row_reg <= row_index;
            col_reg <= col_index;
            alive_reg <= alive_in;
            gen_cnt_reg <= generation_count;
            result_reg <= 1'b0;
        end
        if (cmd.cell_capture)
        begin
            result_reg <= in_range & rd_row[col_sel];
        end
        if (cmd.gen_start)
        begin
            above_reg <= '0;
            row_cnt_reg <= '0;
            changed_reg <= 1'b0;
        end
        if (cmd.gen_prime)
        begin
            mid_reg <= rd_row;
        end
        if (cmd.gen_row)
        begin
            above_reg <= mid_reg;
            mid_reg <= below;
            row_cnt_reg <= row_cnt_reg + RW'(1);
            changed_reg <= changed_reg | changed_now;
            if (last_row)
            begin
                gen_cnt_reg <= gen_cnt_reg - GEN_COUNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            alive_out_reg <= result_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign alive_out = alive_out_reg;

    assign sts.count_zero = (generation_count == '0);
    assign sts.last_row = last_row;
    assign sts.gens_one = (gen_cnt_reg == GEN_COUNT_W'(1));
    assign sts.changed = changed_reg | changed_now;
    assign sts.out_free = !out_valid_reg || !out_stall;

endmodule

FILE: hdl/life_grid_generation_engine.sv
// cell write or read: cell state, then finish loads the result; next item taken in idle
// run: per generation a start and a prime state, then one row per cycle through the grid
// memory's read and write ports; stops early once a generation leaves the grid unchanged
// a waiting result does not block the next transfer; it only holds back the one after
// reset: all rows read as dead through per-row valid flags, no clearing pass; width and
// height return to 64
module life_grid_generation_engine #(
    parameter int MAX_WIDTH = 64,
    parameter int MAX_HEIGHT = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       func,
    input  logic [5:0]                       row_index,
    input  logic [5:0]                       col_index,
    input  logic                             alive_in,
    input  logic [lgge_pkg::GEN_COUNT_W-1:0] generation_count,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic                             alive_out,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [lgge_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lgge_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lgge_pkg::*;

    cmd_t cmd;
    sts_t sts;

    assign cfg_ready = 1'b1;

    lgge_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .func     (func),
        .sts      (sts),
        .cmd      (cmd)
    );

    lgge_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .cfg_valid        (cfg_valid),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .row_index        (row_index),
        .col_index        (col_index),
        .alive_in         (alive_in),
        .generation_count (generation_count),
        .out_stall        (out_stall),
        .out_valid        (out_valid),
        .alive_out        (alive_out)
    );

endmodule
